// File: hdl/ntid_pkg.sv
// shared constants, codes and types of the name to id table
package ntid_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int KEY_W       = 64;
  localparam int ID_W        = 16;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;

  // request codes
  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_LOOKUP   = 2'd1,
    CMD_REVERSE  = 2'd2
  } cmd_t;

  // reply codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // table write enables, one per field
  typedef struct packed {
    logic name;
    logic id;
  } wen_t;

endpackage

// File: hdl/ntid_ifs.sv
// request and reply channel interfaces of the name to id table

interface ntid_req_if;
  import ntid_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] name_key;
  logic [ID_W-1:0]  task_id;

  modport source (output valid, cmd, name_key, task_id, input ready);
  modport sink (input valid, cmd, name_key, task_id, output ready);
endinterface

interface ntid_rsp_if;
  import ntid_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     found_id;
  logic [KEY_W-1:0]    found_name;

  modport source (output valid, status, found_id, found_name, input ready);
  modport sink (input valid, status, found_id, found_name, output ready);
endinterface

// File: hdl/ntid_mem.sv
// name and id storage: one write port, one registered read port
module ntid_mem #(
  parameter int ENTRIES = ntid_pkg::ENTRIES_DEF,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                       clk,
  input  logic [AW-1:0]              rd_addr,
  output logic [ntid_pkg::KEY_W-1:0] rd_name,
  output logic [ntid_pkg::ID_W-1:0]  rd_id,
  input  logic [AW-1:0]              wr_addr,
  input  logic [ntid_pkg::KEY_W-1:0] wr_name,
  input  logic [ntid_pkg::ID_W-1:0]  wr_id,
  input  ntid_pkg::wen_t             wen
);
  import ntid_pkg::*;

  logic [KEY_W-1:0] name_store [ENTRIES];
  logic [ID_W-1:0]  id_store   [ENTRIES];

  // write port, fields enabled separately
  always_ff @(posedge clk) begin
    if (wen.name) begin
      name_store[wr_addr] <= wr_name;
    end
    if (wen.id) begin
      id_store[wr_addr] <= wr_id;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    rd_name <= name_store[rd_addr];
    rd_id   <= id_store[rd_addr];
  end

endmodule

// File: hdl/ntid_ctrl.sv
// request sequencer: table scan, read-modify-write and reply register
module ntid_ctrl #(
  parameter int ENTRIES = ntid_pkg::ENTRIES_DEF,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  ntid_req_if.sink                   req,
  ntid_rsp_if.source                 rsp,
  output logic [AW-1:0]              rd_addr,
  input  logic [ntid_pkg::KEY_W-1:0] rd_name,
  input  logic [ntid_pkg::ID_W-1:0]  rd_id,
  output logic [AW-1:0]              wr_addr,
  output logic [ntid_pkg::KEY_W-1:0] wr_name,
  output logic [ntid_pkg::ID_W-1:0]  wr_id,
  output ntid_pkg::wen_t             wen
);
  import ntid_pkg::*;

  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  state_t           state, state_next;
  logic [CW-1:0]    fill, fill_next;
  logic [CW-1:0]    cmp_idx, idx_next;
  logic [CW-1:0]    nxt;
  logic [CMD_W-1:0] cmd_r, cmd_next;
  logic [KEY_W-1:0] key_r, key_next;
  logic [ID_W-1:0]  id_r, id_next;
  status_t          res_status, res_status_next;
  logic [ID_W-1:0]  res_id, res_id_next;
  logic [KEY_W-1:0] res_name, res_name_next;
  logic             out_valid;
  status_t          out_status;
  logic [ID_W-1:0]  out_id;
  logic [KEY_W-1:0] out_name;
  logic             out_load;
  logic             match;
  logic             dec_en;
  logic             dec_hit;
  logic [CMD_W-1:0] dec_cmd;
  logic [KEY_W-1:0] dec_key;
  logic [ID_W-1:0]  dec_id;

  // entry under compare is the one read in the previous cycle
  assign nxt   = cmp_idx + 1'b1;
  assign match = (cmd_r == CMD_REVERSE) ? (rd_id == id_r) : (rd_name == key_r);

  // next state, scan addressing and request outcome
  always_comb begin
    state_next      = state;
    fill_next       = fill;
    idx_next        = cmp_idx;
    cmd_next        = cmd_r;
    key_next        = key_r;
    id_next         = id_r;
    res_status_next = res_status;
    res_id_next     = res_id;
    res_name_next   = res_name;
    out_load        = 1'b0;
    rd_addr         = '0;
    dec_en          = 1'b0;
    dec_hit         = 1'b0;
    dec_cmd         = cmd_r;
    dec_key         = key_r;
    dec_id          = id_r;
    case (state)
      S_IDLE: begin
        dec_cmd = req.cmd;
        dec_key = req.name_key;
        dec_id  = req.task_id;
        if (req.valid) begin
          cmd_next = req.cmd;
          key_next = req.name_key;
          id_next  = req.task_id;
          idx_next = '0;
          if ((req.cmd == CMD_REGISTER || req.cmd == CMD_LOOKUP ||
               req.cmd == CMD_REVERSE) && fill != '0) begin
            state_next = S_SCAN;
          end else begin
            dec_en = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (nxt < FULL_COUNT) begin
          rd_addr = nxt[AW-1:0];
        end
        idx_next = nxt;
        if (match || nxt == fill) begin
          dec_en  = 1'b1;
          dec_hit = match;
        end
      end
      S_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // write back and reply contents once the outcome is known
    wr_addr = fill[AW-1:0];
    wr_name = dec_key;
    wr_id   = dec_id;
    wen     = '0;
    if (dec_en) begin
      state_next      = S_FINISH;
      res_status_next = ST_NOT_FOUND;
      res_id_next     = '0;
      res_name_next   = '0;
      case (dec_cmd)
        CMD_REGISTER: begin
          if (dec_hit) begin
            wr_addr         = cmp_idx[AW-1:0];
            wen.id          = 1'b1;
            res_status_next = ST_OK;
          end else if (fill != FULL_COUNT) begin
            wen.name        = 1'b1;
            wen.id          = 1'b1;
            fill_next       = fill + 1'b1;
            res_status_next = ST_OK;
          end else begin
            res_status_next = ST_FULL;
          end
        end
        CMD_LOOKUP: begin
          if (dec_hit) begin
            res_id_next     = rd_id;
            res_status_next = ST_OK;
          end
        end
        CMD_REVERSE: begin
          if (dec_hit) begin
            res_name_next   = rd_name;
            res_status_next = ST_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request, scan and result payload
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_next;
    key_r      <= key_next;
    id_r       <= id_next;
    cmp_idx    <= idx_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    res_name   <= res_name_next;
    if (out_load) begin
      out_status <= res_status;
      out_id     <= res_id;
      out_name   <= res_name;
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.found_id   = out_id;
  assign rsp.found_name = out_name;

endmodule

// File: hdl/name_to_id_table_top.sv
// name to id table: one request at a time; the next request is not accepted until the reply
// of the previous one is loaded into the output register. a request compares entries in order
// up to the first match, or up to the fill count on a miss; none on an empty table or unused code.
// the single read port of the table memory sets the pace: one entry compared per cycle.
// the reply passes the result and output registers and is held until taken.
// reset clears the fill count and the handshake state; the memory is not cleared.
module name_to_id_table_top #(
  parameter int ENTRIES = ntid_pkg::ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst,
  ntid_req_if.sink   req,
  ntid_rsp_if.source rsp
);
  import ntid_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_name;
  logic [ID_W-1:0]  rd_id;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_name;
  logic [ID_W-1:0]  wr_id;
  wen_t             wen;

  // sequencer
  ntid_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .rd_addr(rd_addr),
    .rd_name(rd_name),
    .rd_id  (rd_id),
    .wr_addr(wr_addr),
    .wr_name(wr_name),
    .wr_id  (wr_id),
    .wen    (wen)
  );

  // table storage
  ntid_mem #(
    .ENTRIES(ENTRIES)
  ) u_mem (
    .clk    (clk),
    .rd_addr(rd_addr),
    .rd_name(rd_name),
    .rd_id  (rd_id),
    .wr_addr(wr_addr),
    .wr_name(wr_name),
    .wr_id  (wr_id),
    .wen    (wen)
  );

endmodule

// File: hdl/ntid_chk.sv
// port-level assertions of the name to id table, bound to the top level
module ntid_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [ntid_pkg::STATUS_W-1:0] rsp_status,
  input logic [ntid_pkg::ID_W-1:0]     rsp_found_id,
  input logic [ntid_pkg::KEY_W-1:0]    rsp_found_name
);
  import ntid_pkg::*;

  // a stalled reply holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_found_id) && $stable(rsp_found_name))
    else $error("reply changed while stalled");

  // one request at a time: busy after each accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in flight");

  // lookup and reverse results never appear together
  a_found_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_found_id == '0 || rsp_found_name == '0))
    else $error("both found fields nonzero");

  // found fields are zero unless the request succeeded
  a_fail_clears: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_found_id == '0 && rsp_found_name == '0)
    else $error("found field set on failed request");

  // a nonzero id is only reported with ok status
  a_id_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found_id != '0 |-> rsp_status == ST_OK)
    else $error("found id without ok status");

endmodule

bind name_to_id_table_top ntid_chk u_ntid_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_found_id  (rsp.found_id),
  .rsp_found_name(rsp.found_name)
);

// File: sim/name_to_id_table_top_test.sv
// self-checking testbench of the name to id table: directed table, then random requests
module name_to_id_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ntid_pkg::*;

  localparam int N_RANDOM = 1630;
  localparam int LIMIT = 1000000;
  localparam int SETTLE = 40;
  localparam int POOL_N = 48;
  localparam int IDS_N = 12;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_ALPHA = 64'h0000_0061_6870_6c61;
  localparam logic [KEY_W-1:0] KEY_BETA = 64'h0000_0000_6174_6562;

  // one reply as the table should produce it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_id;
    logic [KEY_W-1:0]    found_name;
  } reply_t;

  // one directed request, with its reply typed in where fixed is set
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    logic [ID_W-1:0]     tid;
    logic                fixed;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_id;
    logic [KEY_W-1:0]    found_name;
  } plan_row_t;

  localparam int PLAN_N = 21;
  plan_row_t plan [PLAN_N] = '{
    // empty table: every search misses, unused code answers not found
    '{CMD_LOOKUP,   64'd0,     16'h0000, 1'b1, ST_NOT_FOUND, 16'h0000, 64'd0},
    '{CMD_REVERSE,  64'd0,     16'h0000, 1'b1, ST_NOT_FOUND, 16'h0000, 64'd0},
    '{CMD_UNUSED,   64'd0,     16'h0000, 1'b1, ST_NOT_FOUND, 16'h0000, 64'd0},
    // extreme names and ids
    '{CMD_REGISTER, KEY_ONES,  16'hffff, 1'b1, ST_OK,        16'h0000, 64'd0},
    '{CMD_REGISTER, 64'd0,     16'h0000, 1'b1, ST_OK,        16'h0000, 64'd0},
    '{CMD_LOOKUP,   KEY_ONES,  16'h0000, 1'b1, ST_OK,        16'hffff, 64'd0},
    '{CMD_LOOKUP,   64'd0,     16'hffff, 1'b1, ST_OK,        16'h0000, 64'd0},
    '{CMD_REVERSE,  64'd0,     16'hffff, 1'b1, ST_OK,        16'h0000, KEY_ONES},
    '{CMD_REVERSE,  KEY_ONES,  16'h0000, 1'b1, ST_OK,        16'h0000, 64'd0},
    // duplicate ids resolve to the lowest index, overwrite keeps position
    '{CMD_REGISTER, KEY_ALPHA, 16'h1234, 1'b0, ST_OK,        16'h0000, 64'd0},
    '{CMD_REGISTER, KEY_BETA,  16'h1234, 1'b0, ST_OK,        16'h0000, 64'd0},
    '{CMD_REVERSE,  64'd0,     16'h1234, 1'b0, ST_OK,        16'h0000, 64'd0},
    '{CMD_REGISTER, KEY_ALPHA, 16'h5678, 1'b0, ST_OK,        16'h0000, 64'd0},
    '{CMD_LOOKUP,   KEY_ALPHA, 16'h0000, 1'b0, ST_OK,        16'h0000, 64'd0},
    '{CMD_REVERSE,  KEY_ONES,  16'h1234, 1'b0, ST_OK,        16'h0000, 64'd0},
    '{CMD_REVERSE,  64'd0,     16'h5678, 1'b0, ST_OK,        16'h0000, 64'd0},
    '{CMD_REGISTER, KEY_ONES,  16'h0000, 1'b0, ST_OK,        16'h0000, 64'd0},
    '{CMD_REVERSE,  64'd0,     16'h0000, 1'b0, ST_OK,        16'h0000, 64'd0},
    // miss on a filled table, unused code with every bit set
    '{CMD_LOOKUP,   64'h8000_0000_0000_0001, 16'h8000, 1'b0, ST_OK, 16'h0000, 64'd0},
    '{CMD_UNUSED,   KEY_ONES,  16'hffff, 1'b1, ST_NOT_FOUND, 16'h0000, 64'd0},
    '{CMD_REGISTER, 64'd1,     16'h8000, 1'b0, ST_OK,        16'h0000, 64'd0}
  };

  logic clk;
  logic rst;

  ntid_req_if req_ch ();
  ntid_rsp_if rsp_ch ();

  name_to_id_table_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_names [ENTRIES_DEF];
  logic [ID_W-1:0]  shadow_ids [ENTRIES_DEF];
  int               shadow_fill;

  reply_t pending_replies [$];
  int     errors;
  int     cycle_count;
  bit     quiet;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // first entry below the fill count holding this name, -1 on a miss
  function automatic int shadow_find(input logic [KEY_W-1:0] key);
    for (int i = 0; i < shadow_fill; i++) begin
      if (shadow_names[i] == key) return i;
    end
    return -1;
  endfunction

  // expected reply of one request, shadow table updated as the block would
  function automatic reply_t predict_reply(input logic [CMD_W-1:0] cmd,
                                           input logic [KEY_W-1:0] key,
                                           input logic [ID_W-1:0] tid);
    reply_t r;
    int     hit;
    r.status = ST_NOT_FOUND;
    r.found_id = '0;
    r.found_name = '0;
    case (cmd)
      CMD_REGISTER: begin
        hit = shadow_find(key);
        if (hit >= 0) begin
          shadow_ids[hit] = tid;
          r.status = ST_OK;
        end else if (shadow_fill < ENTRIES_DEF) begin
          shadow_names[shadow_fill] = key;
          shadow_ids[shadow_fill] = tid;
          shadow_fill++;
          r.status = ST_OK;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_LOOKUP: begin
        hit = shadow_find(key);
        if (hit >= 0) begin
          r.status = ST_OK;
          r.found_id = shadow_ids[hit];
        end
      end
      CMD_REVERSE: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_ids[i] == tid) begin
            r.status = ST_OK;
            r.found_name = shadow_names[i];
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // idle length: mostly short, a few long, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // drive one request and wait for its transaction; returns at the accepting edge
  task automatic put_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [ID_W-1:0] tid);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.name_key <= key;
    req_ch.task_id <= tid;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // reply side: check each transaction, then stall at random
  initial begin : reply_check
    int     hold;
    reply_t want;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_replies.size() == 0) begin
          $error("reply with no request outstanding: status %0d", rsp_ch.status);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
            errors++;
          end
          if (rsp_ch.found_id !== want.found_id) begin
            $error("found_id: expected %h, actual %h", want.found_id, rsp_ch.found_id);
            errors++;
          end
          if (rsp_ch.found_name !== want.found_name) begin
            $error("found_name: expected %h, actual %h", want.found_name, rsp_ch.found_name);
            errors++;
          end
        end
        hold = pick_gap();
      end
      if (rst || hold > 0) begin
        rsp_ch.ready <= 1'b0;
        if (hold > 0) hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("name_to_id_table_top verification failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [KEY_W-1:0] name_pool [POOL_N];
    logic [ID_W-1:0]  id_pool [IDS_N];
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  tid;
    reply_t           want;
    int               len;
    int               r;

    errors = 0;
    quiet = 1'b0;
    shadow_fill = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= CMD_REGISTER;
    req_ch.name_key <= '0;
    req_ch.task_id <= '0;

    // name pool: half short padded text names, half full-width random
    for (int i = 0; i < POOL_N; i++) begin
      if (i % 2 == 0) begin
        name_pool[i] = '0;
        len = $urandom_range(1, 8);
        for (int b = 0; b < len; b++) name_pool[i][b*8 +: 8] = 8'($urandom_range(97, 122));
      end else begin
        name_pool[i] = {$urandom, $urandom};
      end
    end
    // small id pool so reverse searches hit and ids repeat
    for (int i = 0; i < IDS_N; i++) id_pool[i] = ID_W'($urandom_range(0, 65535));
    id_pool[0] = '0;
    id_pool[1] = '1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < PLAN_N; i++) begin
      put_request(plan[i].cmd, plan[i].key, plan[i].tid);
      want = predict_reply(plan[i].cmd, plan[i].key, plan[i].tid);
      if (plan[i].fixed) begin
        want.status = plan[i].status;
        want.found_id = plan[i].found_id;
        want.found_name = plan[i].found_name;
      end
      pending_replies.push_back(want);
    end

    // random requests; the table fills early, then full and overwrite cases dominate
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 28) cmd = CMD_REGISTER;
      else if (r < 60) cmd = CMD_LOOKUP;
      else if (r < 94) cmd = CMD_REVERSE;
      else cmd = CMD_UNUSED;
      key = ($urandom_range(0, 99) < 85) ? name_pool[$urandom_range(0, POOL_N-1)]
                                         : {$urandom, $urandom};
      tid = ($urandom_range(0, 99) < 75) ? id_pool[$urandom_range(0, IDS_N-1)]
                                         : ID_W'($urandom_range(0, 65535));
      put_request(cmd, key, tid);
      pending_replies.push_back(predict_reply(cmd, key, tid));
    end
    req_ch.valid <= 1'b0;
    quiet = 1'b0;

    // drain and settle
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0) begin
      $display("name_to_id_table_top verification clean");
    end else begin
      $display("name_to_id_table_top verification failed");
    end
    $finish;
  end

endmodule
